[src/frtg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame rate tier governor package
// Shared widths, constants, register indexes and codes of the governor.
// ----------------------------------------------------------------------------
package frtg_pkg;

  localparam int unsigned WIN_SAMPLES = 64;
  localparam int unsigned WIN_AW      = (WIN_SAMPLES > 1) ? $clog2(WIN_SAMPLES) : 1;
  localparam int unsigned CNT_W       = $clog2(WIN_SAMPLES + 1);

  localparam int unsigned RATE_W   = 14;
  localparam int unsigned DELTA_W  = 22;
  localparam int unsigned SUM_W    = RATE_W + $clog2(WIN_SAMPLES);
  localparam int unsigned TIMER_W  = 24;
  localparam int unsigned INTV_W   = 23;
  localparam int unsigned DETAIL_W = 5;
  localparam int unsigned TIER_W   = 2;
  localparam int unsigned EVT_W    = 2;

  localparam int unsigned DIV_NW = 24;
  localparam int unsigned DIV_DW = 22;
  localparam int unsigned DIV_CW = $clog2(DIV_NW + 1);

  localparam logic [DIV_NW-1:0]   RATE_NUMERATOR = DIV_NW'(16000000);
  localparam logic [RATE_W-1:0]   RATE_MAX       = RATE_W'(16383);
  localparam logic [DETAIL_W-1:0] DETAIL_MIN     = DETAIL_W'(5);
  localparam logic [DETAIL_W-1:0] DETAIL_MAX     = DETAIL_W'(20);
  localparam logic [DETAIL_W-1:0] DETAIL_RESET   = DETAIL_W'(10);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic [RATE_W-1:0] TARGET_RESET    = RATE_W'(480);
  localparam logic [RATE_W-1:0] DOWNGRADE_RESET = RATE_W'(400);
  localparam logic [RATE_W-1:0] UPGRADE_RESET   = RATE_W'(560);
  localparam logic [INTV_W-1:0] INTERVAL_RESET  = INTV_W'(2000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET    = 3'd0,
    REG_DOWNGRADE = 3'd1,
    REG_UPGRADE   = 3'd2,
    REG_INTERVAL  = 3'd3,
    REG_AUTO      = 3'd4,
    REG_DETAIL    = 3'd5,
    REG_MOBILE    = 3'd6
  } cfg_reg_e;

  typedef enum logic [TIER_W-1:0] {
    TIER_LOW  = 2'd0,
    TIER_MED  = 2'd1,
    TIER_HIGH = 2'd2
  } tier_e;

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE = 2'd0,
    EVT_SLOW = 2'd1,
    EVT_FAST = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_UPDATE,
    ST_AVG,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

[src/frtg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame rate tier governor channels
// Request channel carrying frame times and result channel carrying statistics.
// ----------------------------------------------------------------------------
interface frtg_in_if
  import frtg_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [DELTA_W-1:0] delta_us;

  modport source (output valid, output delta_us, input ready);
  modport sink (input valid, input delta_us, output ready);
endinterface

interface frtg_out_if
  import frtg_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [RATE_W-1:0]   current_rate;
  logic [RATE_W-1:0]   average_rate;
  logic [RATE_W-1:0]   min_rate;
  logic [RATE_W-1:0]   max_rate;
  logic [TIER_W-1:0]   tier_now;
  logic                tier_changed;
  logic [EVT_W-1:0]    threshold_event;
  logic                aggressive;
  logic [DETAIL_W-1:0] detail_tenths;

  modport source (
    output valid, output current_rate, output average_rate, output min_rate,
    output max_rate, output tier_now, output tier_changed, output threshold_event,
    output aggressive, output detail_tenths, input ready
  );
  modport sink (
    input valid, input current_rate, input average_rate, input min_rate,
    input max_rate, input tier_now, input tier_changed, input threshold_event,
    input aggressive, input detail_tenths, output ready
  );
endinterface

`default_nettype wire

[src/frame_rate_tier_governor_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame rate tier governor
// Turns frame times into rates, keeps window statistics and steps the
// quality tier and detail scale.
// ----------------------------------------------------------------------------
// Each request on in_if carries one frame time in microseconds. The block
// answers every request with exactly one result on out_if: the frame rate,
// the window average, the minimum and maximum rate, the quality tier and the
// detail scale after that frame.
// One shared bit-serial divider does both divisions of a frame, the rate
// and then the window average. in_if.ready stays low from acceptance until
// the result register is loaded, so the block takes no new frame while one
// is in flight. The result register frees in_if as soon as it is loaded;
// when the receiver stalls, the next frame waits in its last step until the
// pending result is taken.
// Reset clears all statistics, puts the tier at medium and the detail scale
// at 1.0, and loads the register defaults. The user must write registers
// through cfg_we_i, cfg_idx_i and cfg_data_i only while no request is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module frame_rate_tier_governor_unit
  import frtg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  frtg_in_if.sink                    in_if,
  frtg_out_if.source                 out_if,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [RATE_W-1:0] target_q, downgrade_q, upgrade_q;
  logic [INTV_W-1:0] interval_q;
  logic              auto_q, detail_en_q, mobile_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TARGET_RESET;
      downgrade_q <= DOWNGRADE_RESET;
      upgrade_q   <= UPGRADE_RESET;
      interval_q  <= INTERVAL_RESET;
      auto_q      <= 1'b1;
      detail_en_q <= 1'b1;
      mobile_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET:    target_q    <= cfg_data_i[RATE_W-1:0];
        REG_DOWNGRADE: downgrade_q <= cfg_data_i[RATE_W-1:0];
        REG_UPGRADE:   upgrade_q   <= cfg_data_i[RATE_W-1:0];
        REG_INTERVAL:  interval_q  <= cfg_data_i[INTV_W-1:0];
        REG_AUTO:      auto_q      <= cfg_data_i[0];
        REG_DETAIL:    detail_en_q <= cfg_data_i[0];
        REG_MOBILE:    mobile_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic [DELTA_W-1:0]  delta_q;
  logic [RATE_W-1:0]   rate_q, old_q;
  logic [WIN_AW-1:0]   head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [RATE_W-1:0]   low_q, low_d, high_q, high_d;
  logic [TIMER_W-1:0]  timer_q, timer_d, timer_sum;
  logic                check_q, check_d;
  tier_e               tier_q, tier_d;
  logic [DETAIL_W-1:0] detail_q, detail_d;
  event_e              evt_d;
  logic                aggr_d;

  logic [RATE_W-1:0] win_mem [WIN_SAMPLES];

  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;

  logic [RATE_W-1:0] rate_c, avg_c;
  logic              full, first, in_acc, out_free, update_en, finish_en;
  logic [RATE_W+2:0] r5, t4, t6;

  logic              out_valid_q;
  logic [RATE_W-1:0] o_rate_q, o_avg_q, o_min_q, o_max_q;
  logic [TIER_W-1:0] o_tier_q;
  logic              o_chg_q, o_aggr_q;
  logic [EVT_W-1:0]  o_evt_q;
  logic [DETAIL_W-1:0] o_detail_q;

  frtg_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || out_if.ready;
  assign update_en   = (state_q == ST_UPDATE);
  assign finish_en   = (state_q == ST_DONE) && out_free;

  assign rate_c = (delta_q == '0) ? '0 :
                  ((|div_quo[DIV_NW-1:RATE_W]) ? RATE_MAX : div_quo[RATE_W-1:0]);
  assign avg_c  = div_quo[RATE_W-1:0];

  assign full  = (count_q == CNT_W'(WIN_SAMPLES));
  assign first = (count_q == '0);

  always_comb begin
    sum_d     = sum_q - (full ? SUM_W'(old_q) : '0) + SUM_W'(rate_c);
    count_d   = full ? count_q : count_q + CNT_W'(1);
    head_d    = (head_q == WIN_AW'(WIN_SAMPLES - 1)) ? '0 : head_q + WIN_AW'(1);
    low_d     = (first || rate_c < low_q) ? rate_c : low_q;
    high_d    = (first || rate_c > high_q) ? rate_c : high_q;
    timer_sum = timer_q + TIMER_W'(delta_q);
    check_d   = (timer_sum >= TIMER_W'(interval_q));
    timer_d   = check_d ? '0 : timer_sum;
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = RATE_NUMERATOR;
    div_den   = in_if.delta_us;
    state_d   = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          div_start = 1'b1;
          state_d   = ST_RATE;
        end
      end
      ST_RATE: begin
        if (div_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(sum_d);
        div_den   = DIV_DW'(count_d);
        state_d   = ST_AVG;
      end
      ST_AVG: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    tier_d = tier_q;
    evt_d  = EVT_NONE;
    aggr_d = 1'b0;
    if (check_q && auto_q) begin
      if (avg_c < downgrade_q) begin
        evt_d = EVT_SLOW;
        priority if (tier_q == TIER_HIGH) begin
          tier_d = TIER_MED;
        end else if (tier_q == TIER_MED) begin
          tier_d = TIER_LOW;
        end else begin
          aggr_d = 1'b1;
        end
      end else if (avg_c > upgrade_q) begin
        evt_d = EVT_FAST;
        if (tier_q == TIER_LOW) begin
          tier_d = TIER_MED;
        end else if (tier_q == TIER_MED && !mobile_q) begin
          tier_d = TIER_HIGH;
        end
      end
    end
  end

  always_comb begin
    r5       = {rate_q, 2'b00} + (RATE_W+3)'(rate_q);
    t4       = {1'b0, target_q, 2'b00};
    t6       = {1'b0, target_q, 2'b00} + {2'b00, target_q, 1'b0};
    detail_d = detail_q;
    if (detail_en_q) begin
      if (r5 < t4) begin
        if (detail_q < DETAIL_MAX) detail_d = detail_q + DETAIL_W'(1);
      end else if (r5 > t6) begin
        if (detail_q > DETAIL_MIN) detail_d = detail_q - DETAIL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      sum_q    <= '0;
      low_q    <= '0;
      high_q   <= '0;
      timer_q  <= '0;
      check_q  <= 1'b0;
      tier_q   <= TIER_MED;
      detail_q <= DETAIL_RESET;
    end else begin
      state_q <= state_d;
      if (update_en) begin
        head_q  <= head_d;
        count_q <= count_d;
        sum_q   <= sum_d;
        low_q   <= low_d;
        high_q  <= high_d;
        timer_q <= timer_d;
        check_q <= check_d;
      end
      if (finish_en) begin
        tier_q   <= tier_d;
        detail_q <= detail_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      delta_q <= in_if.delta_us;
      old_q   <= win_mem[head_q];
    end
    if (update_en) begin
      rate_q           <= rate_c;
      win_mem[head_q]  <= rate_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_en) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_en) begin
      o_rate_q   <= rate_q;
      o_avg_q    <= avg_c;
      o_min_q    <= low_q;
      o_max_q    <= high_q;
      o_tier_q   <= tier_d;
      o_chg_q    <= (tier_d != tier_q);
      o_evt_q    <= evt_d;
      o_aggr_q   <= aggr_d;
      o_detail_q <= detail_d;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.current_rate    = o_rate_q;
  assign out_if.average_rate    = o_avg_q;
  assign out_if.min_rate        = o_min_q;
  assign out_if.max_rate        = o_max_q;
  assign out_if.tier_now        = o_tier_q;
  assign out_if.tier_changed    = o_chg_q;
  assign out_if.threshold_event = o_evt_q;
  assign out_if.aggressive      = o_aggr_q;
  assign out_if.detail_tenths   = o_detail_q;

endmodule

`default_nettype wire

[src/frtg_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame rate tier governor divider
// Shared restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frtg_divider
  import frtg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_NW-1:0] num_i,
  input  wire logic [DIV_DW-1:0] den_i,
  output logic                   done_o,
  output logic      [DIV_NW-1:0] quo_o
);

  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   diff;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_NW-1]};
    diff    = shifted - {1'b0, den_q};
    if (shifted >= {1'b0, den_q}) begin
      rem_d = diff[DIV_DW-1:0];
      quo_d = {quo_q[DIV_NW-2:0], 1'b1};
    end else begin
      rem_d = shifted[DIV_DW-1:0];
      quo_d = {quo_q[DIV_NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CW'(DIV_NW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - DIV_CW'(1);
      busy_q <= (cnt_q != DIV_CW'(1));
      done_q <= (cnt_q == DIV_CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire
